@@ hw/rtl/msx_pkg.sv @@
// Shared types and constants of the mask outline segment extractor.
`default_nettype none

package msx_pkg;

	localparam int COORD_W = 7;
	localparam int SIZE_W = 7;
	localparam int PIX_W = 6;
	localparam int ALPHA_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int LOAD_CNT_W = 2;

	typedef logic [COORD_W-1:0] coord_t;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT = 1'b1;

	// Row loads issue three reads and take the last word in the cycle after its read.
	localparam logic [LOAD_CNT_W-1:0] LOAD_FIRST = 2'd0;
	localparam logic [LOAD_CNT_W-1:0] LOAD_LAST = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_SCAN,
		S_LOAD,
		S_VSTEP
	} msx_state_t;

	typedef enum logic [1:0] {
		PH_HORZ,
		PH_VERT,
		PH_DONE
	} msx_phase_t;

	typedef struct packed {
		logic run_open;
		logic run_close;
		logic inner_wrap;
		logic outer_wrap;
	} msx_step_t;

endpackage

`default_nettype wire

@@ hw/rtl/msx_scan_step.sv @@
// One boundary step of the outline scan: run open/close decision and segment coordinates.
`default_nettype none

module msx_scan_step import msx_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic                                  horz,
	input  wire logic                                  side,
	input  wire logic signed [$clog2(MAX_SIDE+2):0]    outer,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]         inner,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]         lim_inner,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]         lim_outer,
	input  wire logic [MAX_SIDE-1:0]                   row_up,
	input  wire logic [MAX_SIDE-1:0]                   row_mid,
	input  wire logic [MAX_SIDE-1:0]                   row_dn,
	input  wire logic [MAX_SIDE-1:0]                   rd_row,
	input  wire logic                                  run_is_open,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]         run_start,
	output msx_step_t                                  res,
	output coord_t                                     seg_sx,
	output coord_t                                     seg_sy,
	output coord_t                                     seg_ex,
	output coord_t                                     seg_ey
);

	localparam int CW = $clog2(MAX_SIDE + 1);
	localparam int OW = $clog2(MAX_SIDE + 2) + 1;
	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam logic signed [OW:0] SIDE_S = (OW+1)'(MAX_SIDE);

	function automatic logic bit_at(input logic [MAX_SIDE-1:0] row,
			input logic signed [OW:0] idx);
		logic r;
		r = 1'b0;
		if (idx >= 0 && idx < SIDE_S) begin
			r = row[idx[AW-1:0]];
		end
		return r;
	endfunction

	logic signed [OW:0] o_x;
	logic signed [OW:0] o_inc;
	logic signed [OW:0] o_dec;
	logic signed [OW:0] i_x;
	logic signed [OW:0] lo_x;
	logic signed [OW:0] line_x;
	logic cur;
	logic nxt;
	logic prv;
	logic ok0;
	logic ok1;
	logic hit;

	always_comb begin
		o_x = (OW+1)'(outer);
		o_inc = (OW+1)'(o_x + 1);
		o_dec = (OW+1)'(o_x - 1);
		i_x = $signed((OW+1)'(inner));
		lo_x = $signed((OW+1)'(lim_outer));

		// Horizontal boundaries look at one column of three stacked rows;
		// vertical boundaries look at three neighboring columns of one row.
		if (horz) begin
			cur = bit_at(row_mid, i_x);
			nxt = bit_at(row_dn, i_x);
			prv = bit_at(row_up, i_x);
		end else begin
			cur = bit_at(rd_row, o_x);
			nxt = bit_at(rd_row, o_inc);
			prv = bit_at(rd_row, o_dec);
		end

		ok0 = (inner != lim_inner) && (o_x < lo_x - 1) && (o_x == -1 || !cur);
		ok1 = (inner != lim_inner) && (o_x > 0) && (o_x == lo_x || !cur);
		hit = side ? (ok1 && prv) : (ok0 && nxt);

		res.run_open = hit && !run_is_open;
		res.run_close = !hit && run_is_open;
		res.inner_wrap = side && (({1'b0, inner} + (CW+1)'(1)) > {1'b0, lim_inner});
		res.outer_wrap = res.inner_wrap && (o_inc > lo_x);

		line_x = side ? o_x : o_inc;
		if (horz) begin
			seg_sx = coord_t'(run_start);
			seg_sy = coord_t'(line_x);
			seg_ex = coord_t'(inner);
			seg_ey = coord_t'(line_x);
		end else begin
			seg_sx = coord_t'(line_x);
			seg_sy = coord_t'(run_start);
			seg_ex = coord_t'(line_x);
			seg_ey = coord_t'(inner);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mask_outline_segment_extractor.sv @@
// Top level: mask row memory, scan sequencer, result register and size registers.
// A pixel write reads the row, then writes the modified row back.
// A fetch walks the boundary scan until a run closes or the scan is done: each new horizontal
// line first loads three rows, each horizontal edge position steps both sides, and a vertical
// position reads its row and then steps both sides.
// The result register is loaded at the edge that applies the closing step. Reset clears control
// and scan state and sets both sizes to 1; mask contents stay undefined until written.
`default_nettype none

module mask_outline_segment_extractor import msx_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 req_type,
	input  wire logic [PIX_W-1:0]     pixel_col,
	input  wire logic [PIX_W-1:0]     pixel_row,
	input  wire logic [ALPHA_W-1:0]   pixel_alpha,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output coord_t                    start_x,
	output coord_t                    start_y,
	output coord_t                    end_x,
	output coord_t                    end_y,
	output logic                      scan_done,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_SIDE + 1);
	localparam int OW = $clog2(MAX_SIDE + 2) + 1;
	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	// Size registers
	logic [SIZE_W-1:0] mask_width_q;
	logic [SIZE_W-1:0] mask_height_q;
	logic [CW-1:0] w_eff;
	logic [CW-1:0] h_eff;
	logic [MAX_SIDE-1:0] col_mask;

	// Scan state
	msx_state_t state_q, state_d;
	msx_phase_t phase_q;
	logic signed [OW-1:0] outer_q;
	logic [CW-1:0] inner_q;
	logic side_q;
	logic open0_q, open1_q;
	logic [CW-1:0] start0_q, start1_q;
	logic rows_valid_q;
	logic [LOAD_CNT_W-1:0] ld_cnt_q, ld_cnt_d;
	logic [MAX_SIDE-1:0] row_up_q, row_mid_q, row_dn_q;

	// Memory
	logic [MAX_SIDE-1:0] mem_q [MAX_SIDE];
	logic [MAX_SIDE-1:0] mem_rdata_q;
	logic mem_rok_q;
	logic mem_re;
	logic mem_rok;
	logic [AW-1:0] mem_ra;
	logic mem_we;
	logic [MAX_SIDE-1:0] mem_wdata;
	logic [MAX_SIDE-1:0] rd_row;

	// Pixel write
	logic [AW-1:0] wr_row_q;
	logic [AW-1:0] wr_col_q;
	logic wr_bit_q;
	logic wr_ok_q;

	// Output register
	logic out_valid_q;
	coord_t sx_q, sy_q, ex_q, ey_q;
	logic done_q;

	// Control
	logic in_fire;
	logic cfg_fire;
	logic can_load;
	logic restart;
	logic step_apply;
	logic out_load;
	logic out_done;
	logic ld_capture;
	logic load_done;
	logic horz;
	logic [CW-1:0] lim_inner;
	logic [CW-1:0] lim_outer;
	logic signed [OW:0] ld_row;
	msx_step_t step_res;
	coord_t seg_sx, seg_sy, seg_ex, seg_ey;

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && !in_stall;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		if (mask_width_q == '0) begin
			w_eff = CW'(1);
		end else if (int'(mask_width_q) > MAX_SIDE) begin
			w_eff = CW'(MAX_SIDE);
		end else begin
			w_eff = CW'(mask_width_q);
		end
		if (mask_height_q == '0) begin
			h_eff = CW'(1);
		end else if (int'(mask_height_q) > MAX_SIDE) begin
			h_eff = CW'(MAX_SIDE);
		end else begin
			h_eff = CW'(mask_height_q);
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_SIDE; k++) begin
			col_mask[k] = (CW'(k) < w_eff);
		end
	end

	// Rows outside the height in use and columns outside the width read as clear.
	assign rd_row = mem_rok_q ? (mem_rdata_q & col_mask) : '0;

	assign horz = (phase_q == PH_HORZ);
	assign lim_inner = horz ? w_eff : h_eff;
	assign lim_outer = horz ? h_eff : w_eff;

	always_comb begin
		ld_row = (OW+1)'($signed((OW+1)'(outer_q)) + $signed((OW+1)'(ld_cnt_q)) - 1);
	end

	always_comb begin
		mem_wdata = mem_rdata_q;
		mem_wdata[wr_col_q] = wr_bit_q;
	end

	msx_scan_step #(
		.MAX_SIDE(MAX_SIDE)
	) u_step (
		.horz(horz),
		.side(side_q),
		.outer(outer_q),
		.inner(inner_q),
		.lim_inner(lim_inner),
		.lim_outer(lim_outer),
		.row_up(row_up_q),
		.row_mid(row_mid_q),
		.row_dn(row_dn_q),
		.rd_row(rd_row),
		.run_is_open(side_q ? open1_q : open0_q),
		.run_start(side_q ? start1_q : start0_q),
		.res(step_res),
		.seg_sx(seg_sx),
		.seg_sy(seg_sy),
		.seg_ex(seg_ex),
		.seg_ey(seg_ey)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ld_cnt_d = ld_cnt_q;
		mem_re = 1'b0;
		mem_rok = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		step_apply = 1'b0;
		restart = 1'b0;
		out_load = 1'b0;
		out_done = 1'b0;
		ld_capture = 1'b0;
		load_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cfg_fire) begin
					restart = 1'b1;
				end
				if (in_fire) begin
					if (req_type == REQ_WRITE) begin
						mem_re = 1'b1;
						mem_ra = AW'(pixel_row);
						restart = 1'b1;
						state_d = S_WRITE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_WRITE: begin
				mem_we = wr_ok_q;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				case (phase_q)
					PH_DONE: begin
						if (can_load) begin
							out_load = 1'b1;
							out_done = 1'b1;
							restart = 1'b1;
							state_d = S_IDLE;
						end
					end
					PH_HORZ: begin
						if (!rows_valid_q) begin
							ld_cnt_d = LOAD_FIRST;
							state_d = S_LOAD;
						end else if (!step_res.run_close || can_load) begin
							step_apply = 1'b1;
							if (step_res.run_close) begin
								out_load = 1'b1;
								state_d = S_IDLE;
							end
						end
					end
					PH_VERT: begin
						mem_re = 1'b1;
						mem_rok = (inner_q < h_eff);
						mem_ra = AW'(inner_q);
						state_d = S_VSTEP;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_LOAD: begin
				// Reads rows outer-1, outer, outer+1; each word is captured in the cycle after its read.
				if (ld_cnt_q != LOAD_LAST) begin
					mem_re = 1'b1;
					mem_rok = (ld_row >= 0) && (ld_row < $signed((OW+1)'(h_eff)));
					mem_ra = AW'(ld_row);
				end
				if (ld_cnt_q != LOAD_FIRST) begin
					ld_capture = 1'b1;
				end
				ld_cnt_d = ld_cnt_q + 1'b1;
				if (ld_cnt_q == LOAD_LAST) begin
					load_done = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_VSTEP: begin
				if (!step_res.run_close || can_load) begin
					step_apply = 1'b1;
					if (step_res.run_close) begin
						out_load = 1'b1;
						state_d = S_IDLE;
					end else if (side_q) begin
						state_d = S_SCAN;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_cnt_q <= LOAD_FIRST;
		end else begin
			ld_cnt_q <= ld_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q <= SIZE_W'(1);
			mask_height_q <= SIZE_W'(1);
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_MASK_WIDTH: mask_width_q <= cfg_data;
				CFG_MASK_HEIGHT: mask_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HORZ;
			outer_q <= OW'(-1);
			inner_q <= '0;
			side_q <= 1'b0;
			open0_q <= 1'b0;
			open1_q <= 1'b0;
			start0_q <= '0;
			start1_q <= '0;
			rows_valid_q <= 1'b0;
		end else if (restart) begin
			phase_q <= PH_HORZ;
			outer_q <= OW'(-1);
			inner_q <= '0;
			side_q <= 1'b0;
			open0_q <= 1'b0;
			open1_q <= 1'b0;
			start0_q <= '0;
			start1_q <= '0;
			rows_valid_q <= 1'b0;
		end else begin
			if (load_done) begin
				rows_valid_q <= 1'b1;
			end
			if (step_apply) begin
				if (step_res.run_open) begin
					if (side_q) begin
						open1_q <= 1'b1;
						start1_q <= inner_q;
					end else begin
						open0_q <= 1'b1;
						start0_q <= inner_q;
					end
				end
				if (step_res.run_close) begin
					if (side_q) begin
						open1_q <= 1'b0;
					end else begin
						open0_q <= 1'b0;
					end
				end
				if (!side_q) begin
					side_q <= 1'b1;
				end else begin
					side_q <= 1'b0;
					if (step_res.inner_wrap) begin
						// A new line drops both runs and invalidates the cached rows.
						inner_q <= '0;
						open0_q <= 1'b0;
						open1_q <= 1'b0;
						rows_valid_q <= 1'b0;
						if (step_res.outer_wrap) begin
							outer_q <= OW'(-1);
							phase_q <= (phase_q == PH_HORZ) ? PH_VERT : PH_DONE;
						end else begin
							outer_q <= OW'(outer_q + 1);
						end
					end else begin
						inner_q <= CW'(inner_q + 1'b1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_capture) begin
			row_up_q <= row_mid_q;
			row_mid_q <= row_dn_q;
			row_dn_q <= rd_row;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && req_type == REQ_WRITE) begin
			wr_row_q <= AW'(pixel_row);
			wr_col_q <= AW'(pixel_col);
			wr_bit_q <= (pixel_alpha != '0);
			wr_ok_q <= (int'(pixel_row) < MAX_SIDE) && (int'(pixel_col) < MAX_SIDE);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_row_q] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[mem_ra];
			mem_rok_q <= mem_rok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (out_done) begin
				sx_q <= '0;
				sy_q <= '0;
				ex_q <= '0;
				ey_q <= '0;
				done_q <= 1'b1;
			end else begin
				sx_q <= seg_sx;
				sy_q <= seg_sy;
				ex_q <= seg_ex;
				ey_q <= seg_ey;
				done_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign start_x = sx_q;
	assign start_y = sy_q;
	assign end_x = ex_q;
	assign end_y = ey_q;
	assign scan_done = done_q;

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scan_done) |-> (start_x == '0 && start_y == '0 &&
			end_x == '0 && end_y == '0))
		else $error("done beat carries nonzero coordinates");

	a_rows_horz: assert property (@(posedge clk) disable iff (!arst_n)
		rows_valid_q |-> (phase_q == PH_HORZ))
		else $error("row cache marked valid outside the horizontal pass");

	a_inner_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (inner_q <= lim_inner))
		else $error("inner scan index beyond the line length");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == S_IDLE && out_valid))
		else $error("result beat loaded without the fetch completing");

endmodule

`default_nettype wire
